>>> hw/rtl/rde_pkg.sv
// Package for the radix digit emitter: widths, constants, state encoding,
// controller/datapath command and status structs, digit-to-ASCII mapping.
// No dependencies.
package rde_pkg;

  localparam int NumberWidth = 32;
  localparam int ValueWidth  = 32;
  localparam int RadixWidth  = 6;
  localparam int CharWidth   = 7;
  // quotient bits resolved per divider cycle
  localparam int StepBits    = 8;
  localparam int Chunks      = NumberWidth / StepBits;
  localparam int ChunkWidth  = $clog2(Chunks);
  localparam int CountWidth  = $clog2(NumberWidth + 1);
  localparam int AddrWidth   = $clog2(NumberWidth);

  localparam logic [RadixWidth-1:0] DefaultRadix = RadixWidth'(10);
  localparam logic [RadixWidth-1:0] MinRadix     = RadixWidth'(2);
  localparam logic [RadixWidth-1:0] MaxRadix     = RadixWidth'(36);
  localparam logic [RadixWidth-1:0] DecimalLimit = RadixWidth'(10);
  localparam logic [CharWidth-1:0]  CharZero     = CharWidth'(48);
  localparam logic [CharWidth-1:0]  CharLetterA  = CharWidth'(65);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDiv    = 4'b0010,
    StEmitRd = 4'b0100,
    StEmitWr = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;      // take a new number and radix
    logic div_step;  // resolve one chunk of quotient bits
    logic digit_wr;  // store the finished remainder as a digit
    logic rd_en;     // read the next digit, most significant first
    logic out_load;  // move the read digit into the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;   // this divider cycle finishes the division
    logic quot_zero;  // quotient of this division is zero
    logic store_full; // this digit fills the store
    logic last_pend;  // the digit waiting to be loaded is the final one
    logic out_free;   // output register can take a word this cycle
  } sts_t;

  function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] dx;
    dx = {{(CharWidth - RadixWidth){1'b0}}, d};
    if (d < DecimalLimit) begin
      return CharZero + dx;
    end
    return CharLetterA + dx - {{(CharWidth - RadixWidth){1'b0}}, DecimalLimit};
  endfunction

endpackage

>>> hw/rtl/rde_ctrl.sv
// Controller of the radix digit emitter: one-hot state machine that
// sequences division, digit storage and emission. Uses rde_pkg.
module rde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rde_pkg::sts_t sts_i,
  output rde_pkg::cmd_t cmd_o
);

  rde_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == rde_pkg::StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rde_pkg::StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = rde_pkg::StDiv;
        end
      end
      rde_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.digit_wr = 1'b1;
          if (sts_i.quot_zero || sts_i.store_full) begin
            state_d = rde_pkg::StEmitRd;
          end
        end
      end
      rde_pkg::StEmitRd: begin
        cmd_o.rd_en = 1'b1;
        state_d     = rde_pkg::StEmitWr;
      end
      rde_pkg::StEmitWr: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = sts_i.last_pend ? rde_pkg::StIdle : rde_pkg::StEmitRd;
        end
      end
      default: begin
        state_d = rde_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rde_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/rde_datapath.sv
// Datapath of the radix digit emitter: chunked restoring divider, digit
// store memory, digit count and output register. Uses rde_pkg.
module rde_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rde_pkg::ValueWidth-1:0]   value_i,
  input  logic [rde_pkg::RadixWidth-1:0]   radix_i,
  input  rde_pkg::cmd_t                    cmd_i,
  output rde_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rde_pkg::CharWidth-1:0]    digit_char_o,
  output logic                             last_o
);

  logic [rde_pkg::NumberWidth-1:0] num_q, num_d;
  logic [rde_pkg::RadixWidth-1:0]  rem_q, rem_d;
  logic [rde_pkg::RadixWidth-1:0]  radix_q, radix_n;
  logic [rde_pkg::ChunkWidth-1:0]  chunk_q;
  logic [rde_pkg::CountWidth-1:0]  count_q;
  logic [rde_pkg::RadixWidth-1:0]  rd_data_q;
  logic                            rd_last_q;
  logic                            out_valid_q;
  logic [rde_pkg::CharWidth-1:0]   out_char_q;
  logic                            out_last_q;
  logic [rde_pkg::RadixWidth:0]    div_r;
  logic [rde_pkg::StepBits-1:0]    div_qb;
  logic [rde_pkg::CountWidth-1:0]  count_dec;

  logic [rde_pkg::RadixWidth-1:0] store_mem [rde_pkg::NumberWidth];

  // radix clamp: below two means ten, above 36 saturates
  always_comb begin
    if (radix_i < rde_pkg::MinRadix) begin
      radix_n = rde_pkg::DefaultRadix;
    end else if (radix_i > rde_pkg::MaxRadix) begin
      radix_n = rde_pkg::MaxRadix;
    end else begin
      radix_n = radix_i;
    end
  end

  // StepBits restoring steps on a 7-bit partial remainder
  always_comb begin
    div_r  = {1'b0, rem_q};
    div_qb = '0;
    for (int i = 0; i < rde_pkg::StepBits; i++) begin
      div_r = {div_r[rde_pkg::RadixWidth-1:0], num_q[rde_pkg::NumberWidth-1-i]};
      if (div_r >= {1'b0, radix_q}) begin
        div_r = div_r - {1'b0, radix_q};
        div_qb[rde_pkg::StepBits-1-i] = 1'b1;
      end
    end
    rem_d = div_r[rde_pkg::RadixWidth-1:0];
    num_d = {num_q[rde_pkg::NumberWidth-rde_pkg::StepBits-1:0], div_qb};
  end

  assign count_dec = count_q - rde_pkg::CountWidth'(1);

  assign sts_o.div_done   = (chunk_q == rde_pkg::ChunkWidth'(rde_pkg::Chunks - 1));
  assign sts_o.quot_zero  = (num_d == '0);
  assign sts_o.store_full = (count_q == rde_pkg::CountWidth'(rde_pkg::NumberWidth - 1));
  assign sts_o.last_pend  = rd_last_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      rem_q   <= '0;
      radix_q <= rde_pkg::DefaultRadix;
      chunk_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.load) begin
        num_q   <= value_i[rde_pkg::NumberWidth-1:0];
        rem_q   <= '0;
        radix_q <= radix_n;
        chunk_q <= '0;
        count_q <= '0;
      end else if (cmd_i.div_step) begin
        num_q   <= num_d;
        chunk_q <= chunk_q + rde_pkg::ChunkWidth'(1);
        rem_q   <= cmd_i.digit_wr ? '0 : rem_d;
        if (cmd_i.digit_wr) begin
          count_q <= count_q + rde_pkg::CountWidth'(1);
        end
      end else if (cmd_i.rd_en) begin
        count_q <= count_dec;
      end
    end
  end

  // digit store, least significant digit at address zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.digit_wr) begin
      store_mem[count_q[rde_pkg::AddrWidth-1:0]] <= rem_d;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= store_mem[count_dec[rde_pkg::AddrWidth-1:0]];
      rd_last_q <= (count_q == rde_pkg::CountWidth'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q <= rde_pkg::digit_to_ascii(rd_data_q);
      out_last_q <= rd_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = out_char_q;
  assign last_o       = out_last_q;

endmodule

>>> hw/rtl/radix_digit_emitter.sv
// Radix digit emitter top level: joins rde_ctrl and rde_datapath.
// Uses rde_pkg.
//
// Input channel (in_valid_i/in_ready_o) takes one word: a 32-bit unsigned
// value_i and a 6-bit radix_i. Radix 0 or 1 means ten, above 36 means 36.
// Output channel (out_valid_o/out_ready_i) returns one word per ASCII digit
// ('0'-'9', 'A'-'Z'), most significant first; last_o marks the final one.
// Zero gives a single '0' with last_o set.
// The divider resolves 8 quotient bits a cycle, so each digit is one full
// division of the number, computed chunk by chunk. Emission reads the
// digit store one address per digit, then loads the output register.
// One number is in work at a time; in_ready_o rises again as soon as the
// final digit is in the output register, even if it has not been taken.
// A stalled receiver holds the output word and pauses emission.
// Reset clears the controller and the output valid; the digit store is not
// cleared, since every digit read was written by the same number.
module radix_digit_emitter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rde_pkg::ValueWidth-1:0]   value_i,
  input  logic [rde_pkg::RadixWidth-1:0]   radix_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rde_pkg::CharWidth-1:0]    digit_char_o,
  output logic                             last_o
);

  rde_pkg::cmd_t cmd;
  rde_pkg::sts_t sts;

  rde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rde_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_o       (last_o)
  );

  // a pending output word is never overwritten
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output word overwritten before it was taken");

  // final digit loaded frees the input side on the next cycle
  a_last_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load && sts.last_pend |=> in_ready_o)
    else $error("input not ready after final digit");

  // digits are only stored at the end of a division
  a_wr_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.digit_wr |-> cmd.div_step && sts.div_done)
    else $error("digit stored outside a finished division");

  // emitted words are always legal digit characters
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= rde_pkg::CharZero && digit_char_o <= 7'd57) ||
                    (digit_char_o >= rde_pkg::CharLetterA && digit_char_o <= 7'd90))
    else $error("digit character out of range");

endmodule
